// File: hdl/si2d_pkg.sv
// Package: payload types and constants for the 2D segment intersection block.
package si2d_pkg;
	localparam int COORD_W = 24;
	localparam int FRAC_BITS = 16;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_start_x;
		logic signed [COORD_W-1:0] a_start_y;
		logic signed [COORD_W-1:0] a_end_x;
		logic signed [COORD_W-1:0] a_end_y;
		logic signed [COORD_W-1:0] b_start_x;
		logic signed [COORD_W-1:0] b_start_y;
		logic signed [COORD_W-1:0] b_end_x;
		logic signed [COORD_W-1:0] b_end_y;
	} seg_in_t;

	typedef struct packed {
		logic                      hit;
		logic                      parallel;
		logic signed [COORD_W-1:0] cross_x;
		logic signed [COORD_W-1:0] cross_y;
	} seg_out_t;
endpackage

// File: hdl/segment_intersection_2d_top.sv
// Top level: pipelined 2D segment intersection test with Cramer's rule.
// Pipeline: 23 register stages between the input and out_valid.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Latency is set mostly by the 17-stage restoring divider, one quotient bit per stage.
// Reset (arst_n low, asynchronous) clears all stage valid bits; items in flight are dropped.
// Data registers carry no reset.
module segment_intersection_2d_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  si2d_pkg::seg_in_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output si2d_pkg::seg_out_t  out_data
);
	localparam int CW = si2d_pkg::COORD_W;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int FB = si2d_pkg::FRAC_BITS;
	localparam int QW = FB + 1;
	localparam int NDIV = QW;
	localparam int MW = QW + CW;

	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: differences and box test
	logic v_s1, box_s1;
	logic signed [CW-1:0] ax0_s1, ay0_s1;
	logic signed [DW-1:0] s1x_s1, s1y_s1, s2x_s1, s2y_s1, dx_s1, dy_s1;
	logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	assign ax0 = in_data.a_start_x[CW-1:0];
	assign ay0 = in_data.a_start_y[CW-1:0];
	assign ax1 = in_data.a_end_x[CW-1:0];
	assign ay1 = in_data.a_end_y[CW-1:0];
	assign bx0 = in_data.b_start_x[CW-1:0];
	assign by0 = in_data.b_start_y[CW-1:0];
	assign bx1 = in_data.b_end_x[CW-1:0];
	assign by1 = in_data.b_end_y[CW-1:0];
	logic signed [CW-1:0] amnx, amxx, bmnx, bmxx, amny, amxy, bmny, bmxy;
	logic box_ok;
	always_comb begin
		amnx = (ax0 < ax1) ? ax0 : ax1;
		amxx = (ax0 > ax1) ? ax0 : ax1;
		bmnx = (bx0 < bx1) ? bx0 : bx1;
		bmxx = (bx0 > bx1) ? bx0 : bx1;
		amny = (ay0 < ay1) ? ay0 : ay1;
		amxy = (ay0 > ay1) ? ay0 : ay1;
		bmny = (by0 < by1) ? by0 : by1;
		bmxy = (by0 > by1) ? by0 : by1;
		box_ok = (amnx <= bmxx) && (bmnx <= amxx) && (amny <= bmxy) && (bmny <= amxy);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			box_s1 <= box_ok;
			ax0_s1 <= ax0;
			ay0_s1 <= ay0;
			s1x_s1 <= DW'(ax1) - DW'(ax0);
			s1y_s1 <= DW'(ay1) - DW'(ay0);
			s2x_s1 <= DW'(bx1) - DW'(bx0);
			s2y_s1 <= DW'(by1) - DW'(by0);
			dx_s1  <= DW'(ax0) - DW'(bx0);
			dy_s1  <= DW'(ay0) - DW'(by0);
		end
	end

	// stage 2: six products
	logic v_s2, box_s2;
	logic signed [CW-1:0] ax0_s2, ay0_s2;
	logic signed [DW-1:0] s1x_s2, s1y_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			box_s2 <= box_s1;
			ax0_s2 <= ax0_s1;
			ay0_s2 <= ay0_s1;
			s1x_s2 <= s1x_s1;
			s1y_s2 <= s1y_s1;
			p0_s2  <= PW'(s1x_s1) * PW'(s2y_s1);
			p1_s2  <= PW'(s2x_s1) * PW'(s1y_s1);
			p2_s2  <= PW'(s1x_s1) * PW'(dy_s1);
			p3_s2  <= PW'(s1y_s1) * PW'(dx_s1);
			p4_s2  <= PW'(s2x_s1) * PW'(dy_s1);
			p5_s2  <= PW'(s2y_s1) * PW'(dx_s1);
		end
	end

	// stage 3: determinants
	logic v_s3, box_s3;
	logic signed [CW-1:0] ax0_s3, ay0_s3;
	logic signed [DW-1:0] s1x_s3, s1y_s3;
	logic signed [XW-1:0] div_s3, sn_s3, tn_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			box_s3 <= box_s2;
			ax0_s3 <= ax0_s2;
			ay0_s3 <= ay0_s2;
			s1x_s3 <= s1x_s2;
			s1y_s3 <= s1y_s2;
			div_s3 <= XW'(p0_s2) - XW'(p1_s2);
			sn_s3  <= XW'(p2_s2) - XW'(p3_s2);
			tn_s3  <= XW'(p4_s2) - XW'(p5_s2);
		end
	end

	// stage 4: sign normalize, range test
	logic v_s4, hit_s4, par_s4;
	logic signed [CW-1:0] ax0_s4, ay0_s4;
	logic signed [DW-1:0] s1x_s4, s1y_s4;
	logic [XW-1:0] div_s4, tn_s4;
	logic signed [XW-1:0] dn, snn, tnn;
	logic zero_div, in_rng;
	always_comb begin
		zero_div = (div_s3 == '0);
		dn  = div_s3[XW-1] ? -div_s3 : div_s3;
		snn = div_s3[XW-1] ? -sn_s3 : sn_s3;
		tnn = div_s3[XW-1] ? -tn_s3 : tn_s3;
		in_rng = !snn[XW-1] && !tnn[XW-1] && (snn <= dn) && (tnn <= dn);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			par_s4 <= box_s3 && zero_div;
			hit_s4 <= box_s3 && !zero_div && in_rng;
			ax0_s4 <= ax0_s3;
			ay0_s4 <= ay0_s3;
			s1x_s4 <= s1x_s3;
			s1y_s4 <= s1y_s3;
			div_s4 <= dn;
			tn_s4  <= tnn;
		end
	end

	// divider stages: one quotient bit each, tn <= div so remainder stays below 2*div
	logic                 dv_s5 [NDIV];
	logic                 dhit_s5 [NDIV];
	logic                 dpar_s5 [NDIV];
	logic signed [CW-1:0] dax_s5 [NDIV];
	logic signed [CW-1:0] day_s5 [NDIV];
	logic signed [DW-1:0] dsx_s5 [NDIV];
	logic signed [DW-1:0] dsy_s5 [NDIV];
	logic [XW-1:0]        dd_s5 [NDIV];
	logic [XW:0]          rem_s5 [NDIV];
	logic [QW-1:0]        q_s5 [NDIV];

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		logic [XW:0] r_in, r_sh, r_sub;
		logic [QW-1:0] q_in;
		logic v_in, h_in, p_in;
		logic signed [CW-1:0] ax_in, ay_in;
		logic signed [DW-1:0] sx_in, sy_in;
		logic [XW-1:0] d_in;
		if (g == 0) begin : g_first
			assign r_sh = {1'b0, tn_s4};
			assign q_in = '0;
			assign v_in = v_s4;
			assign h_in = hit_s4;
			assign p_in = par_s4;
			assign ax_in = ax0_s4;
			assign ay_in = ay0_s4;
			assign sx_in = s1x_s4;
			assign sy_in = s1y_s4;
			assign d_in = div_s4;
			assign r_in = r_sh;
		end else begin : g_next
			assign r_in = rem_s5[g-1];
			assign r_sh = {r_in[XW-1:0], 1'b0};
			assign q_in = q_s5[g-1];
			assign v_in = dv_s5[g-1];
			assign h_in = dhit_s5[g-1];
			assign p_in = dpar_s5[g-1];
			assign ax_in = dax_s5[g-1];
			assign ay_in = day_s5[g-1];
			assign sx_in = dsx_s5[g-1];
			assign sy_in = dsy_s5[g-1];
			assign d_in = dd_s5[g-1];
		end
		assign r_sub = r_sh - {1'b0, d_in};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s5[g] <= 1'b0;
			end else if (adv) begin
				dv_s5[g] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dhit_s5[g] <= h_in;
				dpar_s5[g] <= p_in;
				dax_s5[g]  <= ax_in;
				day_s5[g]  <= ay_in;
				dsx_s5[g]  <= sx_in;
				dsy_s5[g]  <= sy_in;
				dd_s5[g]   <= d_in;
				rem_s5[g]  <= r_sub[XW] ? r_sh : r_sub;
				q_s5[g]    <= {q_in[QW-2:0], !r_sub[XW]};
			end
		end
	end

	// stage 6: t * |d|
	logic v_s6, hit_s6, par_s6, nx_s6, ny_s6;
	logic signed [CW-1:0] ax_s6, ay_s6;
	logic [MW-1:0] mx_s6, my_s6;
	logic [DW-1:0] magx, magy;
	localparam int L = NDIV - 1;
	assign magx = dsx_s5[L][DW-1] ? DW'(-dsx_s5[L]) : DW'(dsx_s5[L]);
	assign magy = dsy_s5[L][DW-1] ? DW'(-dsy_s5[L]) : DW'(dsy_s5[L]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= dv_s5[L];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s6 <= dhit_s5[L];
			par_s6 <= dpar_s5[L];
			nx_s6  <= dsx_s5[L][DW-1];
			ny_s6  <= dsy_s5[L][DW-1];
			ax_s6  <= dax_s5[L];
			ay_s6  <= day_s5[L];
			mx_s6  <= MW'(q_s5[L]) * MW'(magx);
			my_s6  <= MW'(q_s5[L]) * MW'(magy);
		end
	end

	// stage 7: output register
	logic [CW-1:0] px, py, cx, cy;
	assign px = mx_s6[FB +: CW];
	assign py = my_s6[FB +: CW];
	assign cx = nx_s6 ? CW'(ax_s6) - px : CW'(ax_s6) + px;
	assign cy = ny_s6 ? CW'(ay_s6) - py : CW'(ay_s6) + py;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.hit      <= hit_s6 || par_s6;
			out_data.parallel <= par_s6;
			out_data.cross_x  <= hit_s6 ? si2d_pkg::COORD_W'(signed'(cx)) : '0;
			out_data.cross_y  <= hit_s6 ? si2d_pkg::COORD_W'(signed'(cy)) : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_par_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.parallel |-> out_data.hit)
		else $error("parallel without hit");
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.parallel |-> out_data.cross_x == '0 && out_data.cross_y == '0)
		else $error("parallel item carries a point");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.cross_x == '0 && out_data.cross_y == '0)
		else $error("miss carries a point");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output changed");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");
`endif
endmodule
